@@ rtl/tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, field widths and codes of the transfer completion scoreboard.
// ----------------------------------------------------------------------------
package tcs_pkg;

	localparam int CMD_W      = 3;
	localparam int ID_W       = 8;
	localparam int TIME_W     = 48;
	localparam int COUNT_W    = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;

	// command codes; the unused codes behave as a status query
	localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FINISH = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_XFER_TOTAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DUE_TIME   = 1'b1;

	typedef logic [1:0] entry_state_t;

	localparam entry_state_t ST_NEEDED   = 2'd0;
	localparam entry_state_t ST_INFLIGHT = 2'd1;
	localparam entry_state_t ST_FINISHED = 2'd2;

	// write port of the entry memory
	typedef struct packed {
		logic             en;
		logic [ID_W-1:0]  addr;
		entry_state_t     data;
	} tcs_wr_t;

endpackage

@@ rtl/tcs_if.sv @@
// ----------------------------------------------------------------------------
// tcs_if
// Valid/ready channels of the scoreboard: command, status and configuration.
// ----------------------------------------------------------------------------
interface tcs_req_if;
	import tcs_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ID_W-1:0]   transfer_id;
	logic              ok;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output cmd, output transfer_id, output ok, output now_ms,
		input ready);
	modport sink (input valid, input cmd, input transfer_id, input ok, input now_ms,
		output ready);
endinterface

interface tcs_rsp_if;
	logic valid;
	logic ready;
	logic start_accepted;
	logic all_done;
	logic all_succeeded;
	logic all_started;
	logic none_in_flight;
	logic is_canceled;
	logic timed_out;

	modport source (output valid, output start_accepted, output all_done,
		output all_succeeded, output all_started, output none_in_flight,
		output is_canceled, output timed_out, input ready);
	modport sink (input valid, input start_accepted, input all_done,
		input all_succeeded, input all_started, input none_in_flight,
		input is_canceled, input timed_out, output ready);
endinterface

interface tcs_cfg_if;
	import tcs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/transfer_completion_scoreboard.sv @@
// ----------------------------------------------------------------------------
// transfer_completion_scoreboard
// Tracks numbered transfers as needed, in flight or finished and returns a
// status transaction for every command.
// ----------------------------------------------------------------------------
//  channel  direction  handshake      payload
//  req      in         valid/ready    cmd, transfer_id, ok, now_ms
//  rsp      out        valid/ready    start_accepted .. timed_out
//  cfg      in         valid/ready    index, data (always ready)
//
// One command per cycle, unless a stalled rsp holds the command stage or the
// first-needed pointer walks; status is registered from the command stage.
// A start that takes the lowest needed id holds its status while the pointer
// walks over started entries. The entry memory is read at acceptance and
// written back when the command stage fires, with the last write forwarded.
// Reset and clear act at once via per-entry started bits; no clearing pass.
// ----------------------------------------------------------------------------
module transfer_completion_scoreboard #(
	parameter int MAX_TRANSFERS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	tcs_req_if.sink    req,
	tcs_rsp_if.source  rsp,
	tcs_cfg_if.sink    cfg
);
	import tcs_pkg::*;

	// ids are 8 bits wide, so no more than 256 entries can ever change
	localparam int DEPTH = (MAX_TRANSFERS < 256) ? MAX_TRANSFERS : 256;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = 17;
	localparam logic [LW-1:0]      MAX_W   = LW'(MAX_TRANSFERS);
	localparam logic [COUNT_W-1:0] PTR_END = COUNT_W'(DEPTH);

	logic [COUNT_W-1:0] xfer_total;
	logic [TIME_W-1:0]  due_time;

	tcs_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.xfer_total (xfer_total),
		.due_time   (due_time)
	);

	// command stage
	logic              vld_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [ID_W-1:0]   id_s1;
	logic              ok_s1;
	logic [TIME_W-1:0] now_s1;

	entry_state_t rd_data_s1;
	tcs_wr_t      wr_c;
	tcs_wr_t      ram_wr;
	tcs_wr_t      fwd_q;
	logic [ID_W-1:0] rd_addr;

	logic [DEPTH-1:0]   started_q;
	logic [COUNT_W-1:0] inflight_q;
	logic [COUNT_W-1:0] finished_q;
	logic               success_q;
	logic               cancel_q;
	logic [COUNT_W-1:0] ptr_q;
	logic               scan_q;

	logic rsp_vld_q;
	logic start_accepted_q;
	logic all_done_q;
	logic all_succeeded_q;
	logic all_started_q;
	logic none_in_flight_q;
	logic is_canceled_q;
	logic timed_out_q;

	logic               req_acc;
	logic               out_free;
	logic               fire;
	logic               scan_stop;
	logic               scan_done;
	logic               valid_id;
	logic [AW-1:0]      idx;
	logic               ent_started;
	entry_state_t       ent_state;
	logic [LW-1:0]      lim;
	logic               acc;
	logic               set_start;
	logic               clr;
	logic               need_scan;
	logic [COUNT_W-1:0] inflight_n;
	logic [COUNT_W-1:0] finished_n;
	logic               success_n;
	logic               cancel_n;
	logic [COUNT_W-1:0] ptr_n;
	logic               done_n;

	assign req_acc   = req.valid && req.ready;
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign fire      = vld_s1 && !scan_q && out_free;
	assign scan_stop = (ptr_q == PTR_END) || !started_q[ptr_q[AW-1:0]];
	assign scan_done = scan_q && scan_stop && out_free;
	assign req.ready = !vld_s1 || fire;

	assign rd_addr = (LW'(req.transfer_id) < MAX_W) ? req.transfer_id : '0;

	tcs_entry_ram #(.DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (req_acc),
		.rd_addr (rd_addr),
		.rd_data (rd_data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (req_acc)
			vld_s1 <= 1'b1;
		else if (fire)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_s1 <= req.cmd;
			id_s1  <= req.transfer_id;
			ok_s1  <= req.ok;
			now_s1 <= req.now_ms;
		end
	end

	assign valid_id    = LW'(id_s1) < MAX_W;
	assign idx         = id_s1[AW-1:0];
	assign ent_started = valid_id && started_q[idx];
	// the transaction ahead may have written this entry after our read
	assign ent_state   = (fwd_q.en && fwd_q.addr == id_s1) ? fwd_q.data : rd_data_s1;
	assign lim         = (LW'(xfer_total) > MAX_W) ? MAX_W : LW'(xfer_total);

	always_comb begin
		acc        = 1'b0;
		set_start  = 1'b0;
		clr        = 1'b0;
		need_scan  = 1'b0;
		wr_c       = '{en: 1'b0, addr: id_s1, data: ST_NEEDED};
		inflight_n = inflight_q;
		finished_n = finished_q;
		success_n  = success_q;
		cancel_n   = cancel_q;
		unique case (cmd_s1)
			CMD_START: begin
				if (valid_id && {1'b0, id_s1} < xfer_total && !ent_started) begin
					acc        = 1'b1;
					set_start  = 1'b1;
					wr_c.en    = 1'b1;
					wr_c.data  = ST_INFLIGHT;
					inflight_n = inflight_q + COUNT_W'(1);
					need_scan  = ({1'b0, id_s1} == ptr_q);
				end
			end
			CMD_FINISH: begin
				if (!ok_s1)
					success_n = 1'b0;
				if (ent_started && ent_state == ST_INFLIGHT) begin
					wr_c.en    = 1'b1;
					wr_c.data  = ST_FINISHED;
					inflight_n = inflight_q - COUNT_W'(1);
					finished_n = finished_q + COUNT_W'(1);
				end
			end
			CMD_CANCEL: cancel_n = 1'b1;
			CMD_CLEAR: begin
				clr        = 1'b1;
				inflight_n = '0;
				finished_n = '0;
				success_n  = 1'b1;
				cancel_n   = 1'b0;
			end
			CMD_QUERY: ;
			default: ;
		endcase
		ptr_n  = clr ? '0 : ptr_q;
		done_n = (finished_n == xfer_total);
	end

	always_comb begin
		ram_wr    = wr_c;
		ram_wr.en = fire && wr_c.en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= '0;
			inflight_q <= '0;
			finished_q <= '0;
			success_q  <= 1'b1;
			cancel_q   <= 1'b0;
			ptr_q      <= '0;
			scan_q     <= 1'b0;
			fwd_q      <= '0;
		end else if (fire) begin
			if (clr)
				started_q <= '0;
			else if (set_start)
				started_q[idx] <= 1'b1;
			inflight_q <= inflight_n;
			finished_q <= finished_n;
			success_q  <= success_n;
			cancel_q   <= cancel_n;
			// the lowest needed id was just taken: walk to the next one
			ptr_q      <= need_scan ? ptr_q + COUNT_W'(1) : ptr_n;
			scan_q     <= need_scan;
			if (wr_c.en)
				fwd_q <= wr_c;
		end else if (scan_q) begin
			if (!scan_stop)
				ptr_q <= ptr_q + COUNT_W'(1);
			else if (out_free)
				scan_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_vld_q <= 1'b0;
		else if ((fire && !need_scan) || scan_done)
			rsp_vld_q <= 1'b1;
		else if (rsp.ready)
			rsp_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			start_accepted_q <= acc;
			all_done_q       <= done_n;
			all_succeeded_q  <= done_n && success_n;
			all_started_q    <= !(LW'(ptr_n) < lim);
			none_in_flight_q <= (inflight_n == '0);
			is_canceled_q    <= cancel_n;
			timed_out_q      <= (now_s1 >= due_time);
		end else if (scan_done) begin
			all_started_q    <= !(LW'(ptr_q) < lim);
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.start_accepted = start_accepted_q;
	assign rsp.all_done       = all_done_q;
	assign rsp.all_succeeded  = all_succeeded_q;
	assign rsp.all_started    = all_started_q;
	assign rsp.none_in_flight = none_in_flight_q;
	assign rsp.is_canceled    = is_canceled_q;
	assign rsp.timed_out      = timed_out_q;

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, inflight_q} + {1'b0, finished_q}) <= (COUNT_W + 1)'(DEPTH))
		else $error("in-flight plus finished exceeds entry count");

	a_ptr_on_needed: assert property (@(posedge clk) disable iff (!arst_n)
		(!scan_q && ptr_q != PTR_END) |-> !started_q[ptr_q[AW-1:0]])
		else $error("first-needed pointer rests on a started entry");

	a_no_rsp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q |-> !rsp_vld_q)
		else $error("status transaction pending during pointer walk");

	a_rsp_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> ($past(fire) || $past(scan_done)))
		else $error("status transaction without a completed command");

endmodule

@@ rtl/tcs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tcs_cfg_regs
// Configuration registers: expected transfer count and deadline.
// ----------------------------------------------------------------------------
module tcs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	tcs_cfg_if.sink                        cfg,
	output logic [tcs_pkg::COUNT_W-1:0]    xfer_total,
	output logic [tcs_pkg::TIME_W-1:0]     due_time
);
	import tcs_pkg::*;

	logic [COUNT_W-1:0] xfer_total_q;
	logic [TIME_W-1:0]  due_time_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfer_total_q <= '0;
			due_time_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_XFER_TOTAL: xfer_total_q <= cfg.data[COUNT_W-1:0];
				REG_DUE_TIME:   due_time_q   <= cfg.data[TIME_W-1:0];
			endcase
		end
	end

	assign xfer_total = xfer_total_q;
	assign due_time   = due_time_q;

endmodule

@@ rtl/tcs_entry_ram.sv @@
// ----------------------------------------------------------------------------
// tcs_entry_ram
// Entry state memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcs_entry_ram #(
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  tcs_pkg::tcs_wr_t           wr,
	input  logic                       rd_en,
	input  logic [tcs_pkg::ID_W-1:0]   rd_addr,
	output tcs_pkg::entry_state_t      rd_data
);
	import tcs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_state_t mem [DEPTH];
	entry_state_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr[AW-1:0]] <= wr.data;
		if (rd_en)
			rd_data_q <= mem[rd_addr[AW-1:0]];
	end

	assign rd_data = rd_data_q;

endmodule

@@ sim/tb_transfer_completion_scoreboard.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_transfer_completion_scoreboard
// Self-checking bench for the transfer completion scoreboard. It tracks every
// entry and flag in its own copy of the table. From that copy it predicts the
// status transaction of each accepted command. It drives directed corner
// cases, full-table and oversized counts, a long response stall and random
// command traffic. Both channels see random idle and stall cycles.
// ----------------------------------------------------------------------------
module tb_transfer_completion_scoreboard;
	import tcs_pkg::*;

	localparam int MAX_TRANSFERS = 256;
	localparam int RANDOM_ITEMS  = 400;
	localparam int DRAIN_SLACK   = 8;
	localparam int END_WAIT      = 2000;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 10;

	// codes the block treats as a status query
	localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic start_accepted;
		logic all_done;
		logic all_succeeded;
		logic all_started;
		logic none_in_flight;
		logic is_canceled;
		logic timed_out;
	} status_t;

	string status_field [0:6] = '{"timed_out", "is_canceled", "none_in_flight",
		"all_started", "all_succeeded", "all_done", "start_accepted"};

	logic clk;
	logic arst_n;

	tcs_req_if req_if ();
	tcs_rsp_if rsp_if ();
	tcs_cfg_if cfg_if ();

	transfer_completion_scoreboard #(
		.MAX_TRANSFERS(MAX_TRANSFERS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if),
		.cfg   (cfg_if)
	);

	// shadow of the scoreboard
	entry_state_t      entry_mem [MAX_TRANSFERS];
	int                finished_cnt;
	int                inflight_cnt;
	logic              success_flag;
	logic              cancel_flag;
	int                cfg_xfer_total = 0;
	logic [TIME_W-1:0] cfg_deadline = '0;

	status_t status_q [$];

	int   err_count = 0;
	int   cycle_count = 0;
	int   hold_left = 0;
	logic src_idle_en = 1'b1;
	logic snk_idle_en = 1'b1;

	status_t got_status;
	status_t want_status;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void note_error(input string msg);
		if (err_count < MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endfunction

	function automatic void clear_scoreboard();
		foreach (entry_mem[i])
			entry_mem[i] = ST_NEEDED;
		finished_cnt = 0;
		inflight_cnt = 0;
		success_flag = 1'b1;
		cancel_flag  = 1'b0;
	endfunction

	// apply one command to the shadow table and return its status
	function automatic status_t predict_status(input logic [CMD_W-1:0] cmd,
		input logic [ID_W-1:0] id, input logic ok, input logic [TIME_W-1:0] now);
		status_t st;
		int      lim;
		logic    needed_left;
		st = '0;
		needed_left = 1'b0;
		case (cmd)
		CMD_START: begin
			if (int'(id) < MAX_TRANSFERS && int'(id) < cfg_xfer_total &&
				entry_mem[id] == ST_NEEDED) begin
				entry_mem[id] = ST_INFLIGHT;
				inflight_cnt++;
				st.start_accepted = 1'b1;
			end
		end
		CMD_FINISH: begin
			if (!ok)
				success_flag = 1'b0;
			if (int'(id) < MAX_TRANSFERS && entry_mem[id] == ST_INFLIGHT) begin
				entry_mem[id] = ST_FINISHED;
				inflight_cnt--;
				finished_cnt++;
			end
		end
		CMD_CANCEL: cancel_flag = 1'b1;
		CMD_CLEAR: clear_scoreboard();
		default: ;
		endcase
		// only entries below both the count and the storage size matter
		lim = (cfg_xfer_total > MAX_TRANSFERS) ? MAX_TRANSFERS : cfg_xfer_total;
		for (int i = 0; i < lim; i++)
			if (entry_mem[i] == ST_NEEDED)
				needed_left = 1'b1;
		st.all_done       = (finished_cnt == cfg_xfer_total);
		st.all_succeeded  = st.all_done && success_flag;
		st.all_started    = !needed_left;
		st.none_in_flight = (inflight_cnt == 0);
		st.is_canceled    = cancel_flag;
		st.timed_out      = (now >= cfg_deadline);
		return st;
	endfunction

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TIME_W-1:0];
	endfunction

	// time stamps bunch around the deadline so that both sides of it are hit
	function automatic logic [TIME_W-1:0] rand_now();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return TIME_MAX;
		else if (r < 5)
			return cfg_deadline + TIME_W'($urandom_range(0, 4)) - TIME_W'(2);
		else
			return rand48();
	endfunction

	// count value with junk above the register width
	function automatic logic [CFG_DATA_W-1:0] count_word(input int count);
		logic [CFG_DATA_W-1:0] w;
		w = rand48();
		w[COUNT_W-1:0] = count[COUNT_W-1:0];
		return w;
	endfunction

	task automatic issue_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
		input logic ok, input logic [TIME_W-1:0] now);
		int gap;
		gap = src_idle_en ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.cmd         <= cmd;
		req_if.transfer_id <= id;
		req_if.ok          <= ok;
		req_if.now_ms      <= now;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		status_q.push_back(predict_status(cmd, id, ok, now));
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
		REG_XFER_TOTAL: cfg_xfer_total = int'(value[COUNT_W-1:0]);
		REG_DUE_TIME: cfg_deadline = value;
		default: ;
		endcase
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly well-formed traffic on ids below the count, some noise
	task automatic rand_item();
		int                lim;
		int                r;
		logic [ID_W-1:0]   id;
		logic [ID_W-1:0]   noise_id;
		logic [CMD_W-1:0]  noise_cmd;
		lim = (cfg_xfer_total > MAX_TRANSFERS) ? MAX_TRANSFERS : cfg_xfer_total;
		noise_id  = ID_W'($urandom());
		noise_cmd = CMD_W'($urandom_range(0, 7));
		if (lim > 0 && $urandom_range(0, 9) != 0)
			id = ID_W'($urandom_range(0, lim - 1));
		else
			id = noise_id;
		r = $urandom_range(0, 99);
		if (r < 40)
			issue_cmd(CMD_START, id, 1'($urandom_range(0, 1)), rand_now());
		else if (r < 75)
			issue_cmd(CMD_FINISH, id, ($urandom_range(0, 19) != 0), rand_now());
		else if (r < 82)
			issue_cmd(CMD_CANCEL, id, 1'($urandom_range(0, 1)), rand_now());
		else if (r < 90)
			issue_cmd(CMD_QUERY, id, 1'($urandom_range(0, 1)), rand_now());
		else if (r < 93)
			issue_cmd(CMD_CLEAR, id, 1'($urandom_range(0, 1)), rand_now());
		else
			issue_cmd(noise_cmd, noise_id, 1'($urandom_range(0, 1)), rand48());
	endtask

	task automatic test_directed();
		write_reg(REG_XFER_TOTAL, count_word(4));
		write_reg(REG_DUE_TIME, 48'd1000);
		issue_cmd(CMD_QUERY, 8'd0, 1'b0, '0);
		issue_cmd(CMD_QUERY, 8'd0, 1'b0, 48'd999);
		issue_cmd(CMD_QUERY, 8'd0, 1'b0, 48'd1000);
		for (int i = 0; i < 4; i++)
			issue_cmd(CMD_START, ID_W'(i), 1'b1, TIME_MAX);
		// repeated start, id at the count and id at the top of storage
		issue_cmd(CMD_START, 8'd0, 1'b1, 48'd5);
		issue_cmd(CMD_START, 8'd4, 1'b1, 48'd5);
		issue_cmd(CMD_START, 8'd255, 1'b1, 48'd5);
		// a failure on an unknown id still clears the success flag
		issue_cmd(CMD_FINISH, 8'd200, 1'b0, 48'd5);
		issue_cmd(CMD_FINISH, 8'd0, 1'b1, 48'd5);
		issue_cmd(CMD_FINISH, 8'd1, 1'b1, 48'd5);
		issue_cmd(CMD_FINISH, 8'd1, 1'b1, 48'd5);
		issue_cmd(CMD_FINISH, 8'd2, 1'b1, 48'd5);
		issue_cmd(CMD_FINISH, 8'd3, 1'b1, 48'd1001);
		issue_cmd(CMD_CANCEL, 8'd0, 1'b0, 48'd5);
		issue_cmd(CMD_SPARE_5, 8'd1, 1'b0, 48'd5);
		issue_cmd(CMD_SPARE_6, 8'd2, 1'b1, 48'd5);
		issue_cmd(CMD_SPARE_7, 8'd255, 1'b1, TIME_MAX);
		issue_cmd(CMD_CLEAR, 8'd0, 1'b0, 48'd5);
		issue_cmd(CMD_START, 8'd3, 1'b1, 48'd5);
		issue_cmd(CMD_FINISH, 8'd3, 1'b1, 48'd5);
	endtask

	task automatic test_count_extremes();
		write_reg(REG_XFER_TOTAL, count_word(0));
		write_reg(REG_DUE_TIME, '0);
		issue_cmd(CMD_CLEAR, 8'd0, 1'b0, '0);
		issue_cmd(CMD_START, 8'd0, 1'b1, '0);
		issue_cmd(CMD_QUERY, 8'd0, 1'b0, '0);
		// fill and finish the whole table
		write_reg(REG_XFER_TOTAL, count_word(MAX_TRANSFERS));
		write_reg(REG_DUE_TIME, TIME_MAX);
		issue_cmd(CMD_CLEAR, 8'd0, 1'b0, 48'd0);
		for (int i = 0; i < MAX_TRANSFERS; i++)
			issue_cmd(CMD_START, ID_W'(i), 1'b1, rand48());
		for (int i = 0; i < MAX_TRANSFERS; i++)
			issue_cmd(CMD_FINISH, ID_W'(i), 1'b1, rand48());
		issue_cmd(CMD_QUERY, 8'd0, 1'b0, TIME_MAX - 48'd1);
		issue_cmd(CMD_QUERY, 8'd0, 1'b0, TIME_MAX);
		// counts beyond storage and a count lowered under a finished table
		write_reg(REG_XFER_TOTAL, count_word(300));
		issue_cmd(CMD_QUERY, 8'd0, 1'b0, '0);
		write_reg(REG_XFER_TOTAL, count_word(511));
		issue_cmd(CMD_QUERY, 8'd0, 1'b0, '0);
		write_reg(REG_XFER_TOTAL, count_word(255));
		issue_cmd(CMD_QUERY, 8'd0, 1'b0, '0);
	endtask

	task automatic test_backpressure();
		write_reg(REG_XFER_TOTAL, count_word(8));
		write_reg(REG_DUE_TIME, rand48());
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		hold_left = 200;
		repeat (40) rand_item();
		// pause the sender until every status has come back
		wait_drained();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		repeat (20) rand_item();
	endtask

	task automatic test_random_traffic();
		int sent;
		int n;
		int r;
		int count;
		logic [TIME_W-1:0] deadline;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				count = 0;
			else if (r == 1)
				count = MAX_TRANSFERS;
			else if (r == 2)
				count = MAX_TRANSFERS - 1;
			else if (r == 3)
				count = $urandom_range(MAX_TRANSFERS + 1, 511);
			else
				count = $urandom_range(1, 16);
			r = $urandom_range(0, 9);
			if (r == 0)
				deadline = '0;
			else if (r == 1)
				deadline = TIME_MAX;
			else if (r < 4)
				deadline = TIME_W'($urandom_range(0, 1000));
			else
				deadline = rand48();
			write_reg(REG_XFER_TOTAL, count_word(count));
			write_reg(REG_DUE_TIME, deadline);
			src_idle_en = ($urandom_range(0, 3) != 0);
			snk_idle_en = ($urandom_range(0, 3) != 0);
			// keep the old entries now and then to change the count mid-job
			if ($urandom_range(0, 9) < 7) begin
				issue_cmd(CMD_CLEAR, ID_W'($urandom()), 1'($urandom_range(0, 1)),
					rand_now());
				sent++;
			end
			n = $urandom_range(40, 120);
			repeat (n) rand_item();
			sent += n;
		end
	endtask

	// status receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				while (hold_left > 0) begin
					@(posedge clk);
					hold_left--;
				end
			end
			stall = snk_idle_en ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got_status = '{rsp_if.start_accepted, rsp_if.all_done, rsp_if.all_succeeded,
				rsp_if.all_started, rsp_if.none_in_flight, rsp_if.is_canceled,
				rsp_if.timed_out};
			if (status_q.size() == 0) begin
				note_error("status transaction with none expected");
			end else begin
				want_status = status_q.pop_front();
				for (int i = 6; i >= 0; i--)
					if (got_status[i] !== want_status[i])
						note_error($sformatf("%s expected %0b, got %0b",
							status_field[i], want_status[i], got_status[i]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int waited;
		arst_n             <= 1'b0;
		req_if.valid       <= 1'b0;
		req_if.cmd         <= CMD_QUERY;
		req_if.transfer_id <= '0;
		req_if.ok          <= 1'b0;
		req_if.now_ms      <= '0;
		cfg_if.valid       <= 1'b0;
		cfg_if.index       <= REG_XFER_TOTAL;
		cfg_if.data        <= '0;
		clear_scoreboard();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_count_extremes();
		test_backpressure();
		test_random_traffic();

		req_if.valid <= 1'b0;
		waited = 0;
		while (status_q.size() != 0 && waited < END_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_SLACK) @(posedge clk);
		if (status_q.size() != 0)
			note_error($sformatf("%0d status transactions never arrived", status_q.size()));
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
